// ----- rtl/ptd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared sizes, command codes and the controller-to-datapath command word
// of the periodic task dispatcher.
// ----------------------------------------------------------------------------
package ptd_pkg;

	localparam int NUM_SLOTS      = 8;
	localparam int PERIOD_BITS    = 16;
	localparam int RUN_COUNT_BITS = 8;

	localparam int SLOT_W = $clog2(NUM_SLOTS);

	localparam int CMD_W      = 2;
	localparam int SLOT_IN_W  = 3;
	localparam int INTERVAL_W = 16;

	// Host command codes
	localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD      = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_DISPATCH = 2'd3;

	// Datapath operations issued by the controller
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_TICK,
		OP_ADD,
		OP_REMOVE,
		OP_DISPATCH
	} ptd_op_t;

	typedef struct packed {
		ptd_op_t           op;
		logic [SLOT_W-1:0] idx;     // slot visited by a tick step
		logic              finish;  // last cycle of the word, latch result
	} ptd_cmd_t;

endpackage : ptd_pkg
`default_nettype wire

// ----- rtl/ptd_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_ctrl
// Command sequencer: takes a command word, steps a tick across all slots,
// issues a single operation otherwise and raises the result strobe.
// ----------------------------------------------------------------------------
module ptd_ctrl
	import ptd_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [CMD_W-1:0] command,
	output logic                  busy,
	output logic                  done,
	output ptd_cmd_t              cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_TICK = 2'd1;
	localparam logic [1:0] ST_OP   = 2'd2;

	localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

	logic [1:0]        state_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [SLOT_W-1:0] cnt_q;
	logic              done_q;

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

	always_comb begin
		cmd.op     = OP_NONE;
		cmd.idx    = cnt_q;
		cmd.finish = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.op = OP_LOAD;
				end
			end
			ST_TICK: begin
				cmd.op     = OP_TICK;
				cmd.finish = (cnt_q == LAST_IDX);
			end
			ST_OP: begin
				cmd.finish = 1'b1;
				unique case (cmd_q)
					CMD_ADD:      cmd.op = OP_ADD;
					CMD_REMOVE:   cmd.op = OP_REMOVE;
					CMD_DISPATCH: cmd.op = OP_DISPATCH;
					default:      cmd.op = OP_NONE;
				endcase
			end
			default: begin
				cmd.op = OP_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmd_q   <= CMD_TICK;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						cmd_q   <= command;
						cnt_q   <= '0;
						state_q <= (command == CMD_TICK) ? ST_TICK : ST_OP;
					end
				end
				ST_TICK: begin
					// advance one slot per cycle
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_OP: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q != ST_IDLE))
		else $error("result strobe without finished work");

	a_accept_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && (state_q == ST_IDLE) |=> (state_q != ST_IDLE))
		else $error("accepted word did not start work");

	a_tick_runs_all: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TICK) && (cnt_q != LAST_IDX) |=> (state_q == ST_TICK))
		else $error("tick left before visiting every slot");

endmodule : ptd_ctrl
`default_nettype wire

// ----- rtl/ptd_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_dp
// Slot table and its single update path, lowest-index ready search and the
// result registers.
// ----------------------------------------------------------------------------
module ptd_dp
	import ptd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ptd_cmd_t              cmd,
	input  wire logic [SLOT_IN_W-1:0]  slot,
	input  wire logic [INTERVAL_W-1:0] interval,
	output logic                       granted,
	output logic [SLOT_IN_W-1:0]       granted_slot,
	output logic                       one_shot_freed,
	output logic                       runs_saturated
);

	localparam logic [RUN_COUNT_BITS-1:0] RUN_MAX = {RUN_COUNT_BITS{1'b1}};

	logic [NUM_SLOTS-1:0]      valid_q;
	logic [PERIOD_BITS-1:0]    period_q [NUM_SLOTS];
	logic [PERIOD_BITS-1:0]    ticks_q  [NUM_SLOTS];
	logic [RUN_COUNT_BITS-1:0] runs_q   [NUM_SLOTS];

	logic [SLOT_IN_W-1:0]      slot_q;
	logic [PERIOD_BITS-1:0]    interval_q;
	logic                      sat_acc_q;

	logic                      granted_q;
	logic [SLOT_IN_W-1:0]      gslot_q;
	logic                      freed_q;
	logic                      sat_q;

	logic [NUM_SLOTS-1:0]      ready;
	logic                      any_ready;
	logic [SLOT_W-1:0]         enc;
	logic [SLOT_W-1:0]         addr;
	logic                      slot_ok;
	logic [PERIOD_BITS-1:0]    rd_period;
	logic [PERIOD_BITS-1:0]    rd_ticks;
	logic [RUN_COUNT_BITS-1:0] rd_runs;
	logic                      step_sat;

	// lowest-index slot with a run pending
	always_comb begin
		enc = '0;
		for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
			ready[k] = valid_q[k] && (runs_q[k] != '0);
			if (ready[k]) begin
				enc = SLOT_W'(k);
			end
		end
	end

	assign any_ready = |ready;
	assign slot_ok   = (32'(slot_q) < NUM_SLOTS);

	always_comb begin
		unique case (cmd.op)
			OP_TICK:     addr = cmd.idx;
			OP_DISPATCH: addr = enc;
			default:     addr = SLOT_W'(slot_q);
		endcase
	end

	assign rd_period = period_q[addr];
	assign rd_ticks  = ticks_q[addr];
	assign rd_runs   = runs_q[addr];

	// a due slot holding its count at the maximum flags saturation
	assign step_sat = (cmd.op == OP_TICK) && valid_q[addr] && (rd_ticks == '0) &&
		!((rd_period == '0) && (rd_runs != '0)) && (rd_runs == RUN_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			unique case (cmd.op)
				OP_ADD: begin
					if (slot_ok) begin
						valid_q[addr] <= 1'b1;
					end
				end
				OP_REMOVE: begin
					if (slot_ok) begin
						valid_q[addr] <= 1'b0;
					end
				end
				OP_DISPATCH: begin
					if (any_ready && (rd_period == '0)) begin
						valid_q[addr] <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				slot_q     <= slot;
				interval_q <= PERIOD_BITS'(interval);
				sat_acc_q  <= 1'b0;
			end
			OP_TICK: begin
				sat_acc_q <= sat_acc_q | step_sat;
				if (valid_q[addr]) begin
					if (rd_ticks == '0) begin
						if (!((rd_period == '0) && (rd_runs != '0))) begin
							ticks_q[addr] <= rd_period;
							if (rd_runs != RUN_MAX) begin
								runs_q[addr] <= rd_runs + 1'b1;
							end
						end
					end else begin
						ticks_q[addr] <= rd_ticks - 1'b1;
					end
				end
			end
			OP_ADD: begin
				if (slot_ok) begin
					period_q[addr] <= interval_q;
					ticks_q[addr]  <= '0;
					runs_q[addr]   <= '0;
				end
			end
			OP_DISPATCH: begin
				if (any_ready) begin
					runs_q[addr] <= rd_runs - 1'b1;
				end
			end
			default: begin
			end
		endcase

		if (cmd.finish) begin
			granted_q <= (cmd.op == OP_DISPATCH) && any_ready;
			gslot_q   <= ((cmd.op == OP_DISPATCH) && any_ready) ?
				SLOT_IN_W'(enc) : '0;
			freed_q   <= (cmd.op == OP_DISPATCH) && any_ready && (rd_period == '0);
			sat_q     <= (cmd.op == OP_TICK) && (sat_acc_q || step_sat);
		end
	end

	assign granted        = granted_q;
	assign granted_slot   = gslot_q;
	assign one_shot_freed = freed_q;
	assign runs_saturated = sat_q;

	a_dispatch_hits_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_DISPATCH) && any_ready |-> ready[enc])
		else $error("dispatch picked a slot with nothing pending");

	a_freed_needs_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_DISPATCH) && any_ready && (rd_period == '0) |=> !valid_q[$past(enc)])
		else $error("granted one-shot slot still valid");

endmodule : ptd_dp
`default_nettype wire

// ----- rtl/periodic_task_dispatcher.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_task_dispatcher
// Fixed-priority periodic task scheduler over NUM_SLOTS task slots.
// ----------------------------------------------------------------------------
// Drive a command word (command, slot, interval) with start; it is taken at
// the rising edge where start is high and busy is low. Every word yields
// exactly one result, shown on granted, granted_slot, one_shot_freed and
// runs_saturated for the single cycle in which done is high. There is no
// back-pressure on results: capture them on done or lose them. A tick
// walks the slot table one slot per cycle through a shared update path and
// holds busy high until the last slot is visited; add, remove and dispatch
// do their work in the operation state and then return to idle. The
// result of any word appears in the cycle after its last busy cycle, the
// same cycle in which the next word may already be taken. Slot index is
// also the task's priority: dispatch grants the lowest valid slot with a
// run pending. Fields that do not apply to a command read zero.
// ----------------------------------------------------------------------------
module periodic_task_dispatcher
	import ptd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [CMD_W-1:0]      command,
	input  wire logic [SLOT_IN_W-1:0]  slot,
	input  wire logic [INTERVAL_W-1:0] interval,
	output logic                       done,
	output logic                       granted,
	output logic [SLOT_IN_W-1:0]       granted_slot,
	output logic                       one_shot_freed,
	output logic                       runs_saturated
);

	ptd_cmd_t cmd;

	// sequencer: owns busy, the slot walk and the result strobe
	ptd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.busy    (busy),
		.done    (done),
		.cmd     (cmd)
	);

	// slot table, ready search and result registers
	ptd_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.slot           (slot),
		.interval       (interval),
		.granted        (granted),
		.granted_slot   (granted_slot),
		.one_shot_freed (one_shot_freed),
		.runs_saturated (runs_saturated)
	);

endmodule : periodic_task_dispatcher
`default_nettype wire

// ----- verif/testbench.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the periodic task dispatcher. Command words are
// driven through the start/busy handshake. A slot-table scoreboard predicts
// the result of each accepted word and compares every done strobe against
// the oldest prediction, field by field. A directed opener is followed by
// random command mixes under changing sender gaps. A tick flood then drives
// a pending count into saturation.
// ----------------------------------------------------------------------------
module testbench;
	import ptd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400_000;
	localparam int unsigned PRINT_CAP   = 40;

	// One predicted result; cmd only labels messages and is never compared
	typedef struct packed {
		logic [CMD_W-1:0]     cmd;
		logic                 granted;
		logic [SLOT_IN_W-1:0] gslot;
		logic                 freed;
		logic                 sat;
	} outcome_t;

	// Slot-table predictor plus the store of outcomes still owed by the block
	class dispatch_board;
		logic                      valid     [NUM_SLOTS];
		logic [PERIOD_BITS-1:0]    period    [NUM_SLOTS];
		logic [PERIOD_BITS-1:0]    countdown [NUM_SLOTS];
		logic [RUN_COUNT_BITS-1:0] runs      [NUM_SLOTS];
		outcome_t                  awaited   [$];
		int unsigned               per_command [4];
		int unsigned               grants, frees, sat_ticks, results, mismatches;

		function new();
			for (int k = 0; k < NUM_SLOTS; k++) begin
				valid[k]     = 1'b0;
				period[k]    = '0;
				countdown[k] = '0;
				runs[k]      = '0;
			end
			for (int c = 0; c < 4; c++)
				per_command[c] = 0;
			grants     = 0;
			frees      = 0;
			sat_ticks  = 0;
			results    = 0;
			mismatches = 0;
		endfunction

		task report(string msg);
			mismatches++;
			if (mismatches <= PRINT_CAP)
				$display("[%0t] MISMATCH: %s", $realtime, msg);
		endtask

		function int unsigned outstanding();
			return awaited.size();
		endfunction

		// Advance the table by one accepted word and queue what it must produce
		function void take_word(logic [CMD_W-1:0] cmd, logic [SLOT_IN_W-1:0] sl,
				logic [INTERVAL_W-1:0] iv);
			outcome_t               o;
			logic [PERIOD_BITS-1:0] per;
			o     = '0;
			o.cmd = cmd;
			per   = PERIOD_BITS'(iv);
			per_command[cmd]++;
			case (cmd)
				CMD_TICK: begin
					for (int k = 0; k < NUM_SLOTS; k++) begin
						if (!valid[k])
							continue;
						if (countdown[k] == '0) begin
							// a one-shot with its run still waiting stays put
							if (period[k] == '0 && runs[k] != '0)
								continue;
							countdown[k] = period[k];
							if (&runs[k])
								o.sat = 1'b1;
							else
								runs[k] = runs[k] + 1'b1;
						end else begin
							countdown[k] = countdown[k] - 1'b1;
						end
					end
					if (o.sat)
						sat_ticks++;
				end
				CMD_ADD: begin
					if (int'(sl) < NUM_SLOTS) begin
						valid[sl]     = 1'b1;
						period[sl]    = per;
						countdown[sl] = '0;
						runs[sl]      = '0;
					end
				end
				CMD_REMOVE: begin
					if (int'(sl) < NUM_SLOTS)
						valid[sl] = 1'b0;
				end
				CMD_DISPATCH: begin
					// lowest index wins
					for (int k = 0; k < NUM_SLOTS; k++) begin
						if (!o.granted && valid[k] && runs[k] != '0) begin
							o.granted = 1'b1;
							o.gslot   = SLOT_IN_W'(k);
							runs[k]   = runs[k] - 1'b1;
							if (period[k] == '0) begin
								valid[k] = 1'b0;
								o.freed  = 1'b1;
							end
						end
					end
					if (o.granted)
						grants++;
					if (o.freed)
						frees++;
				end
				default: ;
			endcase
			awaited.push_back(o);
		endfunction

		task check_outcome(logic g, logic [SLOT_IN_W-1:0] gs, logic f, logic s);
			outcome_t want;
			results++;
			if (awaited.size() == 0) begin
				report($sformatf("result %0d arrived with no word outstanding", results));
				return;
			end
			want = awaited.pop_front();
			if (g !== want.granted)
				report($sformatf("result %0d (cmd %0d) granted %b, want %b",
					results, want.cmd, g, want.granted));
			if (gs !== want.gslot)
				report($sformatf("result %0d (cmd %0d) granted_slot %0d, want %0d",
					results, want.cmd, gs, want.gslot));
			if (f !== want.freed)
				report($sformatf("result %0d (cmd %0d) one_shot_freed %b, want %b",
					results, want.cmd, f, want.freed));
			if (s !== want.sat)
				report($sformatf("result %0d (cmd %0d) runs_saturated %b, want %b",
					results, want.cmd, s, want.sat));
		endtask
	endclass

	// Clock and reset; every input known from time zero
	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  start    = 1'b0;
	logic [CMD_W-1:0]      command  = CMD_TICK;
	logic [SLOT_IN_W-1:0]  slot     = '0;
	logic [INTERVAL_W-1:0] interval = '0;
	logic                  busy;
	logic                  done;
	logic                  granted;
	logic [SLOT_IN_W-1:0]  granted_slot;
	logic                  one_shot_freed;
	logic                  runs_saturated;

	dispatch_board board;
	int unsigned   idle_pct    = 15;
	int unsigned   cycle_count = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	periodic_task_dispatcher i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.command        (command),
		.slot           (slot),
		.interval       (interval),
		.done           (done),
		.granted        (granted),
		.granted_slot   (granted_slot),
		.one_shot_freed (one_shot_freed),
		.runs_saturated (runs_saturated)
	);

	// Capture each result on its done cycle; values seen here are pre-edge
	always @(posedge clk) begin
		if (arst_n && done)
			board.check_outcome(granted, granted_slot, one_shot_freed, runs_saturated);
	end

	// Watchdog: drop the run if the block stops answering
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("periodic_task_dispatcher verification failed");
			$finish;
		end
	end

	// Hand one word to the block. Start stays high on return, so a word that
	// follows without a gap keeps it asserted with no drop in between.
	task automatic issue_word(input logic [CMD_W-1:0] cmd, input logic [SLOT_IN_W-1:0] sl,
			input logic [INTERVAL_W-1:0] iv);
		int unsigned gap;
		if ($urandom_range(99) < idle_pct) begin
			gap = $urandom_range(1, 10);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start    <= 1'b1;
		command  <= cmd;
		slot     <= sl;
		interval <= iv;
		// hold the word until an edge sees start high with busy low
		@(posedge clk);
		while (busy) @(posedge clk);
		board.take_word(cmd, sl, iv);
	endtask

	// Random command mix biased toward short periods, so that countdowns
	// expire and dispatches find work; long periods still show up now and then
	task automatic run_mix(input int unsigned count);
		int unsigned           r;
		logic [CMD_W-1:0]      cmd;
		logic [SLOT_IN_W-1:0]  sl;
		logic [INTERVAL_W-1:0] iv;
		repeat (count) begin
			r = $urandom_range(99);
			if (r < 38)
				cmd = CMD_TICK;
			else if (r < 58)
				cmd = CMD_ADD;
			else if (r < 68)
				cmd = CMD_REMOVE;
			else
				cmd = CMD_DISPATCH;
			sl = SLOT_IN_W'($urandom_range((1 << SLOT_IN_W) - 1));
			r  = $urandom_range(99);
			if (cmd != CMD_ADD || r >= 90)
				iv = INTERVAL_W'($urandom());
			else if (r < 45)
				iv = INTERVAL_W'($urandom_range(3));
			else if (r < 80)
				iv = INTERVAL_W'($urandom_range(15));
			else
				iv = '1;
			issue_word(cmd, sl, iv);
		end
	endtask

	// Stack up runs on a period-1 slot until its pending count pins at the top,
	// then drain a few grants
	task automatic flood_ticks();
		logic [SLOT_IN_W-1:0] hot;
		hot = SLOT_IN_W'($urandom_range((1 << SLOT_IN_W) - 1));
		issue_word(CMD_ADD, hot, 16'd1);
		issue_word(CMD_ADD, SLOT_IN_W'($urandom_range((1 << SLOT_IN_W) - 1)), 16'd2);
		repeat (2 * (1 << RUN_COUNT_BITS) + 48)
			issue_word(CMD_TICK, SLOT_IN_W'($urandom()), INTERVAL_W'($urandom()));
		repeat (16)
			issue_word(CMD_DISPATCH, SLOT_IN_W'($urandom()), INTERVAL_W'($urandom()));
	endtask

	initial begin
		board = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opener: empty table, one-shot hold-off, period extremes,
		// free-slot removal, removal keeping stale runs hidden, overwrite on add
		issue_word(CMD_DISPATCH, 3'd0, 16'h0000);  // nothing ready
		issue_word(CMD_TICK,     3'd0, 16'h0000);  // tick on an empty table
		issue_word(CMD_REMOVE,   3'd5, 16'h0000);  // remove a free slot
		issue_word(CMD_ADD,      3'd7, 16'h0000);  // one-shot
		issue_word(CMD_ADD,      3'd0, 16'hFFFF);  // longest period
		issue_word(CMD_ADD,      3'd3, 16'h0001);
		issue_word(CMD_TICK,     3'd7, 16'hFFFF);  // all three become ready
		issue_word(CMD_TICK,     3'd0, 16'h0000);  // one-shot stays put
		issue_word(CMD_TICK,     3'd0, 16'h0000);  // slot 3 gets a second run
		issue_word(CMD_DISPATCH, 3'd7, 16'hFFFF);  // slot 0 first
		issue_word(CMD_DISPATCH, 3'd0, 16'h0000);  // then slot 3
		issue_word(CMD_REMOVE,   3'd3, 16'h0000);  // slot 3 still holds a run
		issue_word(CMD_DISPATCH, 3'd0, 16'h0000);  // one-shot granted and freed
		issue_word(CMD_DISPATCH, 3'd0, 16'h0000);  // removed run must not show
		issue_word(CMD_ADD,      3'd3, 16'h0002);  // re-add clears the old run
		issue_word(CMD_ADD,      3'd0, 16'h5555);  // overwrite a live slot
		issue_word(CMD_TICK,     3'd0, 16'h0000);
		issue_word(CMD_ADD,      3'd4, 16'hAAAA);
		issue_word(CMD_DISPATCH, 3'd0, 16'h0000);
		issue_word(CMD_DISPATCH, 3'd0, 16'h0000);
		issue_word(CMD_TICK,     3'd0, 16'h0000);
		issue_word(CMD_DISPATCH, 3'd0, 16'h0000);
		issue_word(CMD_ADD,      3'd2, 16'h0000);
		issue_word(CMD_TICK,     3'd0, 16'h0000);
		issue_word(CMD_DISPATCH, 3'd0, 16'h0000);

		// Random part: light gaps, heavy gaps, then back to back
		run_mix(300);
		idle_pct = 46;
		run_mix(300);
		idle_pct = 0;
		flood_ticks();
		run_mix(50);

		// Drain: release start, wait for every owed result, then a short tail
		start <= 1'b0;
		while (board.outstanding() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Covered %0d ticks, %0d adds, %0d removes, %0d dispatches in %0d results.",
			board.per_command[CMD_TICK], board.per_command[CMD_ADD],
			board.per_command[CMD_REMOVE], board.per_command[CMD_DISPATCH], board.results);
		$display("Saw %0d grants, %0d one-shot frees, %0d ticks at a pinned count; %0d mismatches.",
			board.grants, board.frees, board.sat_ticks, board.mismatches);
		if (board.mismatches == 0)
			$display("periodic_task_dispatcher verification clean");
		else
			$display("periodic_task_dispatcher verification failed");
		$finish;
	end

endmodule : testbench
`default_nettype wire

// ----- periodic_task_dispatcher.f -----
rtl/ptd_pkg.sv
rtl/ptd_ctrl.sv
rtl/ptd_dp.sv
rtl/periodic_task_dispatcher.sv
verif/testbench.sv
